// ===== hw/rtl/psort_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psort_pkg
// shared types for the patience sort engine: sequencer states, cell control
// ----------------------------------------------------------------------------
package psort_pkg;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SETTLE,
    ST_DRAIN
  } psort_state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic shift;   // move all held values one cell toward the output
  } psort_ctl_t;

endpackage

// ===== hw/rtl/patience_sort_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patience_sort_engine
// sorts a set of signed values and streams them out in ascending order
// ----------------------------------------------------------------------------
//  channel | dir | tdata          | tlast      | tuser
//  in_     | in  | value          | last       | -
//  out_    | out | sorted_value   | end_of_run | overflowed
//
//  an element enters the cell chain and ripples through it,
//  one cell per cycle, while following elements enter behind it
//  after the last element the chain settles, then
//  one sorted element leaves per cycle while out_tready is high
//  elements past MAX_ITEMS are dropped and flagged on the final transaction
//  reset (rst_n low, synchronous) empties the chain and the output register
//  in_tready is low from the last element until the final result is loaded
// ----------------------------------------------------------------------------
module patience_sort_engine #(
  parameter int MAX_ITEMS = 64,
  parameter int DATA_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((DATA_BITS+7)/8)*8-1:0]       in_tdata,   // value
  input  logic                                 in_tlast,   // last
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((DATA_BITS+7)/8)*8-1:0]       out_tdata,  // sorted_value
  output logic                                 out_tlast,  // end_of_run
  output logic                                 out_tuser   // overflowed
);
  import psort_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 2);
  localparam int TD_W  = ((DATA_BITS+7)/8)*8;

  psort_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;     // elements held in the chain
  logic [CNT_W-1:0] settle_r, settle_nxt;   // settle cycles elapsed
  logic drop_r, drop_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_last_r, out_last_nxt;
  logic out_ovf_r, out_ovf_nxt;
  logic signed [DATA_BITS-1:0] out_data_r, out_data_nxt;

  logic in_accept, room, insert, load;
  logic signed [DATA_BITS-1:0] head_value;
  psort_ctl_t ctl;

  assign in_tready = (state_r == ST_FILL);
  assign in_accept = in_tvalid && in_tready;
  assign room      = (count_r < CNT_W'(MAX_ITEMS));
  assign insert    = in_accept && room;
  // next result moves into the output register when it is free
  assign load      = (state_r == ST_DRAIN) && (count_r != '0) &&
                     (!out_valid_r || out_tready);
  assign ctl.shift = load;

  psort_chain #(.MAX_ITEMS(MAX_ITEMS), .DATA_BITS(DATA_BITS)) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_valid   (insert),
    .in_value   (in_tdata[DATA_BITS-1:0]),
    .head_value (head_value)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    settle_nxt    = settle_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_accept) begin
          if (room) count_nxt = count_r + 1'b1;
          else      drop_nxt  = 1'b1;
          if (in_tlast) begin
            state_nxt  = ST_SETTLE;
            settle_nxt = '0;
          end
        end
      end
      ST_SETTLE: begin
        settle_nxt = settle_r + 1'b1;
        if (settle_r == CNT_W'(MAX_ITEMS)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = head_value;
          out_last_nxt  = (count_r == CNT_W'(1));
          out_ovf_nxt   = (count_r == CNT_W'(1)) && drop_r;
          count_nxt     = count_r - 1'b1;
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_FILL;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      count_r     <= '0;
      settle_r    <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      settle_r    <= settle_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TD_W'(unsigned'(out_data_r));
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

// ===== hw/rtl/psort_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psort_cell
// one cell of the sorting chain: keeps the smaller value, passes the larger on
// ----------------------------------------------------------------------------
module psort_cell #(
  parameter int DATA_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  psort_pkg::psort_ctl_t       ctl,
  input  logic                        in_valid,
  input  logic signed [DATA_BITS-1:0] in_value,
  input  logic                        right_valid,
  input  logic signed [DATA_BITS-1:0] right_value,
  output logic                        hold_valid,
  output logic signed [DATA_BITS-1:0] hold_value,
  output logic                        pass_valid,
  output logic signed [DATA_BITS-1:0] pass_value
);
  import psort_pkg::*;

  logic                        hold_valid_r, hold_valid_nxt;
  logic signed [DATA_BITS-1:0] hold_value_r, hold_value_nxt;
  logic                        pass_valid_r, pass_valid_nxt;
  logic signed [DATA_BITS-1:0] pass_value_r, pass_value_nxt;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_value_nxt = hold_value_r;
    pass_valid_nxt = 1'b0;
    pass_value_nxt = pass_value_r;
    if (ctl.shift) begin
      hold_valid_nxt = right_valid;
      hold_value_nxt = right_value;
    end else if (in_valid) begin
      if (!hold_valid_r) begin
        hold_valid_nxt = 1'b1;
        hold_value_nxt = in_value;
      end else if (in_value < hold_value_r) begin
        hold_value_nxt = in_value;
        pass_valid_nxt = 1'b1;
        pass_value_nxt = hold_value_r;
      end else begin
        pass_valid_nxt = 1'b1;
        pass_value_nxt = in_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      pass_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      pass_valid_r <= pass_valid_nxt;
    end
    hold_value_r <= hold_value_nxt;
    pass_value_r <= pass_value_nxt;
  end

  assign hold_valid = hold_valid_r;
  assign hold_value = hold_value_r;
  assign pass_valid = pass_valid_r;
  assign pass_value = pass_value_r;

endmodule

// ===== hw/rtl/psort_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psort_chain
// row of sorting cells; cell 0 holds the smallest value once settled
// ----------------------------------------------------------------------------
module psort_chain #(
  parameter int MAX_ITEMS = 64,
  parameter int DATA_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  psort_pkg::psort_ctl_t       ctl,
  input  logic                        in_valid,
  input  logic signed [DATA_BITS-1:0] in_value,
  output logic signed [DATA_BITS-1:0] head_value
);
  import psort_pkg::*;

  logic                        fwd_valid [MAX_ITEMS+1];
  logic signed [DATA_BITS-1:0] fwd_value [MAX_ITEMS+1];
  logic                        hv        [MAX_ITEMS+1];
  logic signed [DATA_BITS-1:0] hval      [MAX_ITEMS+1];

  assign fwd_valid[0]    = in_valid;
  assign fwd_value[0]    = in_value;
  assign hv[MAX_ITEMS]   = 1'b0;
  assign hval[MAX_ITEMS] = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    psort_cell #(.DATA_BITS(DATA_BITS)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .in_valid    (fwd_valid[i]),
      .in_value    (fwd_value[i]),
      .right_valid (hv[i+1]),
      .right_value (hval[i+1]),
      .hold_valid  (hv[i]),
      .hold_value  (hval[i]),
      .pass_valid  (fwd_valid[i+1]),
      .pass_value  (fwd_value[i+1])
    );
  end

  // the last cell never overflows: the sequencer limits the element count
  assign head_value = hval[0];

endmodule

// ===== hw/rtl/psort_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psort_checker
// port-level checks for the patience sort engine
// ----------------------------------------------------------------------------
module psort_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tlast,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tlast,
  input logic out_tuser
);

  // overflow flag only on the final transaction of a run
  a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast) else $error("overflow flag off final");

  // input closes after the last element is taken
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready) else $error("input open");

  // output register empty right after a reset cycle
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid after reset");

  // stalled result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");

endmodule

bind patience_sort_engine psort_checker u_psort_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== dv/patience_sort_engine_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patience_sort_engine_checker
// watches both stream channels, models the pile sort and compares every
// output transaction against the predicted ascending sequence
// ----------------------------------------------------------------------------
module patience_sort_engine_checker #(
  parameter int MAX_ITEMS = 64,
  parameter int DATA_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [((DATA_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [((DATA_BITS+7)/8)*8-1:0] out_tdata,
  input  logic                           out_tlast,
  input  logic                           out_tuser,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic [DATA_BITS-1:0] value;
    logic                 eor;
    logic                 ovf;
  } sorted_item_t;

  // patience piles: each pile is a queue, element [$] is the top
  logic signed [DATA_BITS-1:0] piles[MAX_ITEMS][$];
  int                          pile_cnt;
  int                          elem_cnt;
  bit                          dropped;
  sorted_item_t                sorted_q[$];

  assign pending = sorted_q.size();

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic place_element(input logic signed [DATA_BITS-1:0] v);
    int lo, hi, mid;
    lo = 0;
    hi = pile_cnt;
    if (elem_cnt >= MAX_ITEMS) begin
      dropped = 1;
      return;
    end
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (piles[mid][$] >= v) hi = mid;
      else lo = mid + 1;
    end
    if (lo >= pile_cnt) pile_cnt = lo + 1;
    piles[lo].push_back(v);
    elem_cnt++;
  endtask

  task automatic drain_piles();
    int best, total;
    sorted_item_t r;
    total = elem_cnt;
    for (int k = 0; k < total; k++) begin
      best = -1;
      for (int p = 0; p < pile_cnt; p++)
        if (piles[p].size() != 0 && (best < 0 || piles[p][$] < piles[best][$])) best = p;
      r.value = piles[best].pop_back();
      r.eor = (k + 1 == total);
      r.ovf = r.eor ? dropped : 1'b0;
      sorted_q.push_back(r);
    end
    pile_cnt = 0;
    elem_cnt = 0;
    dropped = 0;
  endtask

  initial begin
    fail_count = 0;
    pile_cnt = 0;
    elem_cnt = 0;
    dropped = 0;
  end

  always @(posedge clk) begin
    sorted_item_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected output %0d", $signed(out_tdata[DATA_BITS-1:0])));
      end else begin
        e = sorted_q.pop_front();
        if (out_tdata[DATA_BITS-1:0] !== e.value)
          report_mismatch($sformatf("value got %0d exp %0d",
            $signed(out_tdata[DATA_BITS-1:0]), $signed(e.value)));
        if (out_tlast !== e.eor)
          report_mismatch($sformatf("tlast got %b exp %b", out_tlast, e.eor));
        if (out_tuser !== e.ovf)
          report_mismatch($sformatf("tuser got %b exp %b", out_tuser, e.ovf));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      place_element(in_tdata[DATA_BITS-1:0]);
      if (in_tlast) drain_piles();
    end
  end

endmodule

// ===== dv/patience_sort_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patience_sort_engine_tb
// drives sets of signed values into the sort engine with random idling on
// both channels; a side checker predicts and compares the sorted stream
// ----------------------------------------------------------------------------
module patience_sort_engine_tb;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_BITS = 32;
  localparam int TDW       = ((DATA_BITS+7)/8)*8;

  logic           clk;
  logic           rst_n;
  logic           in_tvalid;
  logic           in_tready;
  logic [TDW-1:0] in_tdata;   // value
  logic           in_tlast;   // last
  logic           out_tvalid;
  logic           out_tready;
  logic [TDW-1:0] out_tdata;  // sorted_value
  logic           out_tlast;  // end_of_run
  logic           out_tuser;  // overflowed
  int             fail_count;
  int             pending;
  bit             quiet;      // no idling in the final stretch
  int             sent;

  patience_sort_engine #(.MAX_ITEMS(MAX_ITEMS), .DATA_BITS(DATA_BITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  patience_sort_engine_checker #(.MAX_ITEMS(MAX_ITEMS), .DATA_BITS(DATA_BITS)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit: far above the slowest legal run
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: ready toggles in random bursts
  initial begin
    int n;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (quiet || $urandom_range(0, 3) != 0) begin
        out_tready <= 1;
      end else begin
        n = $urandom_range(1, 8);
        out_tready <= 0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // one transaction; optional idle burst first, valid held until accepted
  // valid stays high afterwards, the next call or the caller drops it
  task automatic send_value(input logic [DATA_BITS-1:0] v, input bit lst);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      in_tvalid <= 0;
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= TDW'(v);
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [DATA_BITS-1:0] rand_value(input int mode);
    case (mode)
      0: return DATA_BITS'($urandom_range(0, 7)) - 4;   // dense duplicates
      1: return {1'b1, {(DATA_BITS-1){1'b0}}} + DATA_BITS'($urandom_range(0, 2));
      2: return {1'b0, {(DATA_BITS-1){1'b1}}} - DATA_BITS'($urandom_range(0, 2));
      default: return DATA_BITS'($urandom());
    endcase
  endfunction

  task automatic send_set(input int len, input int mode);
    for (int i = 0; i < len; i++)
      send_value(rand_value(mode == 4 ? $urandom_range(0, 3) : mode), i == len - 1);
  endtask

  initial begin
    int len;
    in_tvalid = 0;
    in_tdata  = '0;
    in_tlast  = 0;
    quiet = 0;
    sent = 0;
    rst_n = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, single element, descending, ascending, ties
    send_value({1'b0, {(DATA_BITS-1){1'b1}}}, 0);
    send_value({1'b1, {(DATA_BITS-1){1'b0}}}, 0);
    send_value('0, 0);
    send_value('1, 0);
    send_value(DATA_BITS'(1), 1);
    send_value(DATA_BITS'(42), 1);
    for (int i = 0; i < 5; i++) send_value(DATA_BITS'(5 - i), i == 4);
    for (int i = 0; i < 5; i++) send_value(DATA_BITS'(i), i == 4);
    for (int i = 0; i < 4; i++) send_value(DATA_BITS'(7), i == 3);

    // pause until the sorted stream is fully drained
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);

    // capacity overflow set: more than MAX_ITEMS elements
    send_set(MAX_ITEMS + 3, 4);
    // exactly full set
    send_set(MAX_ITEMS, 4);

    // random sets, mostly small
    while (sent < 480) begin
      if (sent > 400) quiet = 1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(32, MAX_ITEMS)
                                        : $urandom_range(1, 12);
      send_set(len, $urandom_range(0, 4));
    end

    quiet = 1;
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (MAX_ITEMS * 4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/psort_pkg.sv
hw/rtl/psort_cell.sv
hw/rtl/psort_chain.sv
hw/rtl/patience_sort_engine.sv
hw/rtl/psort_checker.sv
dv/patience_sort_engine_checker.sv
dv/patience_sort_engine_tb.sv
